// ===== design/rsp_pkg.sv =====
// shared constants, codes and types of the rtp h264 stream probe
// no dependencies
`default_nettype none

package rsp_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int COUNTER_BITS     = 32;
    localparam int NUM_COUNTERS     = 15;
    localparam int NUM_NAL_SLOTS    = 5;
    localparam int RTP_HDR_BYTES    = 12;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic [2:0] CLS_BAD    = 3'd0;
    localparam logic [2:0] CLS_WSTART = 3'd1;
    localparam logic [2:0] CLS_WCONT  = 3'd2;
    localparam logic [2:0] CLS_RAW    = 3'd3;
    localparam logic [2:0] CLS_PLAIN  = 3'd4;

    localparam logic [3:0] C_PACKETS  = 4'd0;
    localparam logic [3:0] C_BYTES    = 4'd1;
    localparam logic [3:0] C_PT       = 4'd2;
    localparam logic [3:0] C_MARKER   = 4'd3;
    localparam logic [3:0] C_BAD      = 4'd4;
    localparam logic [3:0] C_SPS      = 4'd5;
    localparam logic [3:0] C_PPS      = 4'd6;
    localparam logic [3:0] C_IDR      = 4'd7;
    localparam logic [3:0] C_SEI      = 4'd8;
    localparam logic [3:0] C_WSTART   = 4'd9;
    localparam logic [3:0] C_WCONT    = 4'd10;
    localparam logic [3:0] C_RAW      = 4'd11;
    localparam logic [3:0] C_UNKNOWN  = 4'd12;
    localparam logic [3:0] C_GAP      = 4'd13;
    localparam logic [3:0] C_TSCHANGE = 4'd14;

    localparam logic [2:0] SLOT_IDR   = 3'd0;
    localparam logic [2:0] SLOT_SEI   = 3'd1;
    localparam logic [2:0] SLOT_SPS   = 3'd2;
    localparam logic [2:0] SLOT_PPS   = 3'd3;
    localparam logic [2:0] SLOT_OTHER = 3'd4;

    typedef logic [COUNTER_BITS-1:0] counter_t;
    typedef logic [NUM_NAL_SLOTS-1:0][15:0] nal_counts_t;

    typedef struct packed {
        logic        fire;
        logic        ok;
        logic [15:0] len;
        logic        pt_hit;
        logic        marker;
        logic        gap;
        logic        ts_change;
        logic [2:0]  cls;
        nal_counts_t nal;
    } commit_t;

endpackage

`default_nettype wire

// ===== design/rsp_if.sv =====
// handshake channels of the rtp h264 stream probe: input items, results, config
// no dependencies
`default_nettype none

interface rsp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [3:0] counter_select;
    modport source (output valid, action, data_byte, last_byte, counter_select, input ready);
    modport sink (input valid, action, data_byte, last_byte, counter_select, output ready);
endinterface

interface rsp_out_if;
    logic        valid;
    logic        ready;
    logic        report_kind;
    logic [31:0] counter_value;
    logic        packet_ok;
    logic [2:0]  payload_class;
    logic        sequence_gap;
    modport source (output valid, report_kind, counter_value, packet_ok, payload_class,
                    sequence_gap, input ready);
    modport sink (input valid, report_kind, counter_value, packet_ok, payload_class,
                  sequence_gap, output ready);
endinterface

interface rsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] watched_payload_type;
    modport source (output valid, watched_payload_type, input ready);
    modport sink (input valid, watched_payload_type, output ready);
endinterface

`default_nettype wire

// ===== design/rsp_parser.sv =====
// per-byte rtp header parse, payload scan and packet-end evaluation
// depends on rsp_pkg
`default_nettype none

module rsp_parser
    import rsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_en,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic [6:0] watched_pt,
    output commit_t         commit
);

    logic [15:0]  pos_reg, pos_next;
    logic [7:0]   fhb_reg, fhb_next;
    logic [7:0]   shb_reg, shb_next;
    logic [15:0]  seq_reg, seq_next;
    logic [31:0]  ts_reg, ts_next;
    logic [15:0]  ext_reg, ext_next;
    logic [18:0]  ps_reg, ps_next;
    logic [15:0]  lseq_reg, lseq_next;
    logic [31:0]  lts_reg, lts_next;
    logic         hist_reg, hist_next;
    logic [1:0]   zrun_reg, zrun_next;
    logic         expect_reg, expect_next;
    logic [7:0]   head_reg, head_next;
    nal_counts_t  pend_reg, pend_next;
    logic [2:0]   cls_reg, cls_next;
    logic         ov_reg, ov_next;

    logic         ov;
    logic [6:0]   hbase;
    logic [18:0]  idx;
    logic [15:0]  len;
    logic [18:0]  rem;
    logic         ok;
    nal_counts_t  pend_fin;

    function automatic nal_counts_t pend_nal(nal_counts_t cnt, logic [4:0] t);
        nal_counts_t r;
        logic [2:0]  slot;
        r = cnt;
        if (t >= 5'd5 && t <= 5'd8)
            slot = 3'(t - 5'd5);
        else
            slot = SLOT_OTHER;
        if (t != 5'd0 && r[slot] != 16'hFFFF)
            r[slot] = r[slot] + 16'd1;
        return r;
    endfunction

    assign ov    = ov_reg | (pos_reg == 16'hFFFF);
    assign hbase = 7'(RTP_HDR_BYTES) + {1'b0, fhb_reg[3:0], 2'b00};
    assign idx   = {3'b000, pos_reg} - ps_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        fhb_next    = fhb_reg;
        shb_next    = shb_reg;
        seq_next    = seq_reg;
        ts_next     = ts_reg;
        ext_next    = ext_reg;
        ps_next     = ps_reg;
        lseq_next   = lseq_reg;
        lts_next    = lts_reg;
        hist_next   = hist_reg;
        zrun_next   = zrun_reg;
        expect_next = expect_reg;
        head_next   = head_reg;
        pend_next   = pend_reg;
        cls_next    = cls_reg;
        ov_next     = ov_reg;
        len         = 16'd0;
        rem         = 19'd0;
        ok          = 1'b0;
        pend_fin    = pend_reg;
        commit      = '0;

        if (byte_en)
        begin
            ov_next = ov;
            if (!ov)
            begin
                if (pos_reg == 16'd0)
                begin
                    fhb_next = data_byte;
                    ps_next  = 19'(RTP_HDR_BYTES) + {13'd0, data_byte[3:0], 2'b00}
                             + (data_byte[4] ? 19'd4 : 19'd0);
                end
                else if (pos_reg == 16'd1)
                    shb_next = data_byte;
                else if (pos_reg < 16'd4)
                    seq_next = {seq_reg[7:0], data_byte};
                else if (pos_reg < 16'd8)
                    ts_next = {ts_reg[23:0], data_byte};

                if (pos_reg >= 16'(RTP_HDR_BYTES) && fhb_reg[4])
                begin
                    if (pos_reg == {9'd0, hbase} + 16'd2)
                        ext_next = {data_byte, 8'h00};
                    else if (pos_reg == {9'd0, hbase} + 16'd3)
                    begin
                        ext_next = ext_reg | {8'h00, data_byte};
                        ps_next  = {12'd0, hbase} + 19'd4 + {1'b0, ext_next, 2'b00};
                    end
                end

                if (pos_reg >= 16'(RTP_HDR_BYTES) && {3'b000, pos_reg} >= ps_reg)
                begin
                    if (idx == 19'd0)
                    begin
                        head_next = data_byte;
                        cls_next  = (data_byte >= 8'h25 && data_byte <= 8'h28)
                                  ? CLS_RAW : CLS_PLAIN;
                    end
                    else if (idx == 19'd1 && head_reg == 8'h3C)
                    begin
                        if (data_byte == 8'h87)
                            cls_next = CLS_WSTART;
                        else if (data_byte == 8'h07)
                            cls_next = CLS_WCONT;
                    end
                    if (expect_reg)
                    begin
                        pend_next   = pend_nal(pend_reg, data_byte[4:0]);
                        expect_next = 1'b0;
                        zrun_next   = 2'd0;
                    end
                    else if (data_byte == 8'h00)
                    begin
                        if (zrun_reg != 2'd3)
                            zrun_next = zrun_reg + 2'd1;
                    end
                    else if (data_byte == 8'h01 && zrun_reg == 2'd3)
                    begin
                        expect_next = 1'b1;
                        zrun_next   = 2'd0;
                    end
                    else
                        zrun_next = 2'd0;
                end
                pos_next = pos_reg + 16'd1;
            end

            if (last_byte)
            begin
                len = ov ? 16'hFFFF : pos_reg + 16'd1;
                rem = {3'b000, len} - ps_next;
                ok  = !ov && len >= 16'(RTP_HDR_BYTES) && len <= 16'(MAX_PACKET_BYTES)
                    && fhb_next[7:6] == 2'b10;
                if (fhb_next[4] && (16'(RTP_HDR_BYTES) + {10'd0, fhb_next[3:0], 2'b00}
                                    + 16'd4) > len)
                    ok = 1'b0;
                if (ps_next >= {3'b000, len})
                    ok = 1'b0;
                if (fhb_next[5] && (data_byte == 8'h00 || {11'd0, data_byte} > rem))
                    ok = 1'b0;

                pend_fin = pend_next;
                if (cls_next == CLS_RAW)
                    pend_fin = pend_nal(pend_next, head_next[4:0]);

                commit.fire      = 1'b1;
                commit.ok        = ok;
                commit.len       = len;
                commit.pt_hit    = shb_next[6:0] == watched_pt;
                commit.marker    = shb_next[7];
                commit.gap       = hist_reg && seq_next != lseq_reg + 16'd1;
                commit.ts_change = hist_reg && ts_next != lts_reg;
                commit.cls       = ok ? cls_next : CLS_BAD;
                commit.nal       = pend_fin;

                if (ok)
                begin
                    lseq_next = seq_next;
                    lts_next  = ts_next;
                    hist_next = 1'b1;
                end

                pos_next    = 16'd0;
                zrun_next   = 2'd0;
                expect_next = 1'b0;
                head_next   = 8'h00;
                cls_next    = CLS_PLAIN;
                ov_next     = 1'b0;
                pend_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            fhb_reg    <= '0;
            shb_reg    <= '0;
            seq_reg    <= '0;
            ts_reg     <= '0;
            ext_reg    <= '0;
            ps_reg     <= '0;
            lseq_reg   <= '0;
            lts_reg    <= '0;
            hist_reg   <= 1'b0;
            zrun_reg   <= '0;
            expect_reg <= 1'b0;
            head_reg   <= '0;
            pend_reg   <= '0;
            cls_reg    <= CLS_PLAIN;
            ov_reg     <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            fhb_reg    <= fhb_next;
            shb_reg    <= shb_next;
            seq_reg    <= seq_next;
            ts_reg     <= ts_next;
            ext_reg    <= ext_next;
            ps_reg     <= ps_next;
            lseq_reg   <= lseq_next;
            lts_reg    <= lts_next;
            hist_reg   <= hist_next;
            zrun_reg   <= zrun_next;
            expect_reg <= expect_next;
            head_reg   <= head_next;
            pend_reg   <= pend_next;
            cls_reg    <= cls_next;
            ov_reg     <= ov_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/rsp_counters.sv =====
// bank of wrapping event counters: packet-end commit, clear and read
// depends on rsp_pkg
`default_nettype none

module rsp_counters
    import rsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire commit_t     commit,
    input  wire logic        clear,
    input  wire logic [3:0]  sel,
    output logic      [31:0] rd_value
);

    counter_t [NUM_COUNTERS-1:0] cnt_reg, cnt_next;

    assign rd_value = (sel < 4'(NUM_COUNTERS)) ? 32'(cnt_reg[sel]) : 32'd0;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (clear)
            cnt_next = '0;
        else if (commit.fire)
        begin
            cnt_next[C_PACKETS] = cnt_reg[C_PACKETS] + counter_t'(1);
            cnt_next[C_BYTES]   = cnt_reg[C_BYTES] + counter_t'(commit.len);
            if (!commit.ok)
                cnt_next[C_BAD] = cnt_reg[C_BAD] + counter_t'(1);
            else
            begin
                if (commit.pt_hit)
                    cnt_next[C_PT] = cnt_reg[C_PT] + counter_t'(1);
                if (commit.marker)
                    cnt_next[C_MARKER] = cnt_reg[C_MARKER] + counter_t'(1);
                if (commit.gap)
                    cnt_next[C_GAP] = cnt_reg[C_GAP] + counter_t'(1);
                if (commit.ts_change)
                    cnt_next[C_TSCHANGE] = cnt_reg[C_TSCHANGE] + counter_t'(1);
                if (commit.cls == CLS_WCONT)
                    cnt_next[C_WCONT] = cnt_reg[C_WCONT] + counter_t'(1);
                else
                begin
                    if (commit.cls == CLS_WSTART)
                        cnt_next[C_WSTART] = cnt_reg[C_WSTART] + counter_t'(1);
                    if (commit.cls == CLS_RAW)
                        cnt_next[C_RAW] = cnt_reg[C_RAW] + counter_t'(1);
                    cnt_next[C_IDR] = cnt_reg[C_IDR] + counter_t'(commit.nal[SLOT_IDR]);
                    cnt_next[C_SEI] = cnt_reg[C_SEI] + counter_t'(commit.nal[SLOT_SEI]);
                    cnt_next[C_SPS] = cnt_reg[C_SPS] + counter_t'(commit.nal[SLOT_SPS])
                                    + counter_t'(commit.cls == CLS_WSTART);
                    cnt_next[C_PPS] = cnt_reg[C_PPS] + counter_t'(commit.nal[SLOT_PPS]);
                    cnt_next[C_UNKNOWN] = cnt_reg[C_UNKNOWN]
                                        + counter_t'(commit.nal[SLOT_OTHER]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

`default_nettype wire

// ===== design/rtp_h264_stream_probe.sv =====
// top level of the rtp h264 stream probe: input register, config, result register
// depends on rsp_pkg, rsp_if, rsp_parser, rsp_counters
`default_nettype none

// One item per clock: every packet byte, counter read or counter clear is
// registered at the input and handled from the input register by the parser
// and counter bank once the result register is free; its result item is then
// registered, and a new item is taken every cycle while the result side is
// ready. While a result waits unaccepted, the next item waits in the input register.
// Only the final byte of a packet and counter reads produce a result item.

module rtp_h264_stream_probe
    import rsp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rsp_in_if.sink    item_in,
    rsp_out_if.source result_out,
    rsp_cfg_if.sink   cfg
);

    logic        in_vld_reg;
    logic [1:0]  act_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [3:0]  sel_reg;
    logic [6:0]  wpt_reg;
    logic        out_vld_reg, out_vld_next;
    logic        kind_reg;
    logic [31:0] value_reg;
    logic        ok_reg;
    logic [2:0]  cls_reg;
    logic        gap_reg;

    logic        advance;
    logic        byte_en;
    logic        do_clear;
    logic        do_read;
    logic        produce;
    logic [31:0] rd_value;
    commit_t     commit;

    assign advance  = in_vld_reg && (!out_vld_reg || result_out.ready);
    assign byte_en  = advance && act_reg == ACT_BYTE;
    assign do_clear = advance && act_reg == ACT_CLEAR;
    assign do_read  = advance && act_reg == ACT_READ;
    assign produce  = do_read || commit.fire;

    assign item_in.ready = !in_vld_reg || advance;
    assign cfg.ready     = 1'b1;

    assign result_out.valid         = out_vld_reg;
    assign result_out.report_kind   = kind_reg;
    assign result_out.counter_value = value_reg;
    assign result_out.packet_ok     = ok_reg;
    assign result_out.payload_class = cls_reg;
    assign result_out.sequence_gap  = gap_reg;

    assign out_vld_next = produce ? 1'b1 : (result_out.ready ? 1'b0 : out_vld_reg);

    rsp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_en    (byte_en),
        .data_byte  (byte_reg),
        .last_byte  (last_reg),
        .watched_pt (wpt_reg),
        .commit     (commit)
    );

    rsp_counters u_counters (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (commit),
        .clear    (do_clear),
        .sel      (sel_reg),
        .rd_value (rd_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            wpt_reg     <= 7'd96;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (item_in.ready)
                in_vld_reg <= item_in.valid;
            if (cfg.valid)
                wpt_reg <= cfg.watched_payload_type;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            act_reg  <= item_in.action;
            byte_reg <= item_in.data_byte;
            last_reg <= item_in.last_byte;
            sel_reg  <= item_in.counter_select;
        end
        if (produce)
        begin
            kind_reg  <= !do_read;
            value_reg <= do_read ? rd_value : 32'd0;
            ok_reg    <= !do_read && commit.ok;
            cls_reg   <= do_read ? CLS_BAD : commit.cls;
            gap_reg   <= !do_read && commit.ok && commit.gap;
        end
    end

endmodule

`default_nettype wire
